// ===== sv/dkx_pkg.sv =====
// ----------------------------------------------------------------------------
// dkx_pkg
// Types, constants and key tables shared by the dual-key xor stream decrypt
// unit and its submodules.
// ----------------------------------------------------------------------------
package dkx_pkg;

   // header and key geometry
   localparam int HdrLen      = 7;
   localparam int ShortPeriod = 13;
   localparam int LongPeriod  = 17;

   localparam int CntW   = 3;
   localparam int ShortW = 4;
   localparam int LongW  = 5;

   localparam logic [CntW-1:0]   HdrLast   = CntW'(HdrLen - 1);
   localparam logic [CntW-1:0]   CntLimit  = CntW'(HdrLen);
   localparam logic [ShortW-1:0] ShortLast = ShortW'(ShortPeriod - 1);
   localparam logic [ShortW-1:0] ShortLim  = ShortW'(ShortPeriod);
   localparam logic [LongW-1:0]  LongLast  = LongW'(LongPeriod - 1);
   localparam logic [LongW-1:0]  LongLim   = LongW'(LongPeriod);

   // decoder phase
   typedef enum logic [1:0] {
      PH_MATCH = 2'd0,
      PH_BODY  = 2'd1,
      PH_PASS  = 2'd2
   } dkx_phase_type;

   // request payload
   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_end;
   } dkx_req_type;

   // response payload
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_present;
      logic       stream_end;
      logic       run_end;
   } dkx_rsp_type;

   // one burst of results: header prefix replay, then a tail result
   typedef struct packed {
      logic [CntW-1:0] prefix_len;
      logic [7:0]      tail_byte;
      logic            tail_present;
      logic            tail_end;
   } dkx_job_type;

   // header text
   function automatic logic [7:0] hdr_byte(input logic [CntW-1:0] idx);
      logic [7:0] val;
      val = 8'h00;
      unique case (idx)
         3'd0:    val = "R";
         3'd1:    val = "S";
         3'd2:    val = "A";
         3'd3:    val = "4";
         3'd4:    val = "0";
         3'd5:    val = "9";
         3'd6:    val = "6";
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   // period-13 key
   function automatic logic [7:0] short_key(input logic [ShortW-1:0] idx);
      logic [7:0] val;
      val = 8'h00;
      unique case (idx)
         4'd0:    val = "t";
         4'd1:    val = "h";
         4'd2:    val = "e";
         4'd3:    val = "o";
         4'd4:    val = "c";
         4'd5:    val = "r";
         4'd6:    val = "a";
         4'd7:    val = "c";
         4'd8:    val = "y";
         4'd9:    val = " ";
         4'd10:   val = "s";
         4'd11:   val = "u";
         4'd12:   val = "x";
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   // period-17 key
   function automatic logic [7:0] long_key(input logic [LongW-1:0] idx);
      logic [7:0] val;
      val = 8'h00;
      unique case (idx)
         5'd0:    val = "m";
         5'd1:    val = "u";
         5'd2:    val = "t";
         5'd3:    val = "a";
         5'd4:    val = "n";
         5'd5:    val = "t";
         5'd6:    val = " ";
         5'd7:    val = "t";
         5'd8:    val = "e";
         5'd9:    val = "c";
         5'd10:   val = "h";
         5'd11:   val = "n";
         5'd12:   val = "o";
         5'd13:   val = "l";
         5'd14:   val = "o";
         5'd15:   val = "g";
         5'd16:   val = "y";
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

// ===== sv/dkx_core.sv =====
// ----------------------------------------------------------------------------
// dkx_core
// Header matcher and key sequencer: updates the per-file state on each
// accepted request and forms the result burst that the request causes.
// ----------------------------------------------------------------------------
module dkx_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  dkx_pkg::dkx_req_type req,
   output logic                job_load,
   output dkx_pkg::dkx_job_type job
);

   dkx_pkg::dkx_phase_type phase_ff, phase_in;
   logic [dkx_pkg::CntW-1:0]   count_ff, count_in;
   logic [dkx_pkg::ShortW-1:0] short_ff, short_in;
   logic [dkx_pkg::LongW-1:0]  long_ff, long_in;

   logic [dkx_pkg::CntW-1:0]   cnt;
   logic [dkx_pkg::ShortW-1:0] si;
   logic [dkx_pkg::LongW-1:0]  li;
   logic                       hit;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dkx_pkg::PH_MATCH;
         count_ff <= '0;
         short_ff <= '0;
         long_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         short_ff <= short_in;
         long_ff  <= long_in;
      end
   end

   // indices forced back into range
   assign cnt = (count_ff >= dkx_pkg::CntLimit) ? '0 : count_ff;
   assign si  = (short_ff >= dkx_pkg::ShortLim) ? '0 : short_ff;
   assign li  = (long_ff >= dkx_pkg::LongLim) ? '0 : long_ff;
   assign hit = (req.data_byte == dkx_pkg::hdr_byte(cnt));

   // next state and result burst
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      short_in = short_ff;
      long_in  = long_ff;
      job_load = 1'b0;
      job.prefix_len   = '0;
      job.tail_byte    = req.data_byte;
      job.tail_present = 1'b1;
      job.tail_end     = req.file_end;

      unique case (phase_ff)
         dkx_pkg::PH_BODY: begin
            job_load      = 1'b1;
            job.tail_byte = req.data_byte ^ dkx_pkg::long_key(li) ^ dkx_pkg::short_key(si);
            short_in = (si == dkx_pkg::ShortLast) ? '0 : si + 1'b1;
            long_in  = (li == dkx_pkg::LongLast) ? '0 : li + 1'b1;
            if (req.file_end) begin
               phase_in = dkx_pkg::PH_MATCH;
               count_in = '0;
               short_in = '0;
               long_in  = '0;
            end
         end
         dkx_pkg::PH_PASS: begin
            job_load = 1'b1;
            if (req.file_end) begin
               phase_in = dkx_pkg::PH_MATCH;
               count_in = '0;
               short_in = '0;
               long_in  = '0;
            end
         end
         default: begin
            // header matching, also the unused phase code
            if (hit && cnt == dkx_pkg::HdrLast) begin
               count_in = '0;
               short_in = '0;
               long_in  = '0;
               if (req.file_end) begin
                  // file is exactly the header: bare end marker
                  job_load         = 1'b1;
                  job.tail_byte    = '0;
                  job.tail_present = 1'b0;
                  job.tail_end     = 1'b1;
                  phase_in         = dkx_pkg::PH_MATCH;
               end else begin
                  phase_in = dkx_pkg::PH_BODY;
               end
            end else if (hit) begin
               if (req.file_end) begin
                  // short file: replay prefix, this byte closes the file
                  job_load       = 1'b1;
                  job.prefix_len = cnt;
                  phase_in       = dkx_pkg::PH_MATCH;
                  count_in       = '0;
                  short_in       = '0;
                  long_in        = '0;
               end else begin
                  phase_in = dkx_pkg::PH_MATCH;
                  count_in = cnt + 1'b1;
               end
            end else begin
               // mismatch: replay prefix, then pass through
               job_load       = 1'b1;
               job.prefix_len = cnt;
               count_in       = '0;
               if (req.file_end) begin
                  phase_in = dkx_pkg::PH_MATCH;
                  short_in = '0;
                  long_in  = '0;
               end else begin
                  phase_in = dkx_pkg::PH_PASS;
               end
            end
         end
      endcase
   end

endmodule

// ===== sv/dkx_emit.sv =====
// ----------------------------------------------------------------------------
// dkx_emit
// Result register: holds one result burst and steps through the header
// prefix replay and the tail result under response backpressure.
// ----------------------------------------------------------------------------
module dkx_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  dkx_pkg::dkx_job_type job,
   output logic                 free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dkx_pkg::dkx_rsp_type rsp_data
);

   logic                     valid_ff;
   dkx_pkg::dkx_job_type     job_ff;
   logic [dkx_pkg::CntW-1:0] idx_ff;
   logic                     tail_beat;
   logic                     done;

   assign tail_beat = (idx_ff == job_ff.prefix_len);
   assign done      = valid_ff && rsp_ready && tail_beat;
   assign free      = !valid_ff || done;
   assign rsp_valid = valid_ff;

   // burst control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (done) begin
         valid_ff <= 1'b0;
      end else if (valid_ff && rsp_ready) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // burst payload
   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= job;
      end
   end

   // prefix replay from the header text, then the tail
   always_comb begin
      if (tail_beat) begin
         rsp_data.out_byte     = job_ff.tail_byte;
         rsp_data.byte_present = job_ff.tail_present;
         rsp_data.stream_end   = job_ff.tail_end;
         rsp_data.run_end      = 1'b1;
      end else begin
         rsp_data.out_byte     = dkx_pkg::hdr_byte(idx_ff);
         rsp_data.byte_present = 1'b1;
         rsp_data.stream_end   = 1'b0;
         rsp_data.run_end      = 1'b0;
      end
   end

endmodule

// ===== sv/dual_key_xor_stream_decrypt_unit.sv =====
// ----------------------------------------------------------------------------
// dual_key_xor_stream_decrypt_unit
// Header-detecting dual repeating-key xor decryptor for a byte stream.
// ----------------------------------------------------------------------------
// the first result of a request is registered and shows in the cycle after the request is accepted
// throughput: one request per cycle unless a pending result is stalled by rsp_ready;
//   a header mismatch or short file replays up to six held header bytes first
// the burst counter in the result register steps the replay on each taken response
// reset: synchronous; clears phase, header count, key indices and output valid
module dual_key_xor_stream_decrypt_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dkx_pkg::dkx_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dkx_pkg::dkx_rsp_type rsp_data
);

   logic                 accept;
   logic                 job_load;
   logic                 free;
   dkx_pkg::dkx_job_type job;

   // a request is taken whenever the result register frees up this cycle
   assign req_ready = free;
   assign accept    = req_valid && free;

   dkx_core u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .job_load (job_load),
      .job      (job)
   );

   dkx_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && job_load),
      .job       (job),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/dkx_checker.sv =====
// ----------------------------------------------------------------------------
// dkx_checker
// Port-level checks of the response stream of the decrypt unit.
// ----------------------------------------------------------------------------
module dkx_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input dkx_pkg::dkx_rsp_type rsp_data
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // a bare end marker closes both the file and the run
   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_present |-> rsp_data.stream_end && rsp_data.run_end)
      else $error("bare marker without end flags");

   // file end is always the last result of its request
   a_end_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stream_end |-> rsp_data.run_end)
      else $error("stream end before run end");

   // replay burst continues without a gap
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.run_end |=> rsp_valid)
      else $error("gap inside replay burst");

   // nothing pending after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind dual_key_xor_stream_decrypt_unit dkx_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
